@@ rtl/ldfr_pkg.sv @@
// shared types and constants for the linear duty fade ramp
`default_nettype none

package ldfr_pkg;

    localparam int DUTY_W     = 8;
    localparam int DUR_W      = 16;
    localparam int DIV_STEPS  = DUR_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [DUTY_W-1:0] DUTY_MAX         = 8'hFF;
    localparam logic [DUR_W-1:0]  DEFAULT_INTERVAL = 16'd4;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_FADE    = 2'd1,
        CMD_SLEEP   = 2'd2,
        CMD_RESTORE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/ldfr_div.sv @@
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module ldfr_div
    import ldfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DUR_W-1:0]  dividend,
    input  wire logic [DUTY_W-1:0] divisor,
    output logic                   done,
    output logic [DUR_W-1:0]       quotient
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DUTY_W-1:0]     rem_reg, rem_next;
    logic [DUR_W-1:0]      quo_reg, quo_next;
    logic [DUTY_W-1:0]     dvs_reg, dvs_next;
    logic [DUTY_W:0]       trial;
    logic                  ge;

    assign trial = {rem_reg, quo_reg[DUR_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DUTY_W'(trial - {1'b0, dvs_reg}) : trial[DUTY_W-1:0];
            quo_next = {quo_reg[DUR_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ rtl/ldfr_dp.sv @@
// datapath: ramp state, tick step logic, divider and result register
`default_nettype none

module ldfr_dp
    import ldfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_cmd_t         cmd,
    output dp_status_t             status,
    input  wire logic              cfg_we,
    input  wire logic              cfg_data,
    input  wire logic [1:0]        command,
    input  wire logic [DUTY_W-1:0] target_duty,
    input  wire logic [DUR_W-1:0]  duration_ms,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DUTY_W-1:0]      duty,
    output logic                   pwm_write,
    output logic                   idle
);

    logic              en_reg, en_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [DUTY_W-1:0] tgt_reg, tgt_next;
    dir_t              dir_reg, dir_next;
    logic [DUR_W-1:0]  ival_reg, ival_next;
    logic [DUR_W-1:0]  elap_reg, elap_next;
    logic              wrote_reg, wrote_next;
    logic              ovld_reg, ovld_next;
    logic [DUTY_W-1:0] oduty_reg;
    logic              owr_reg;
    logic              oidle_reg;

    cmd_t              cmd_in;
    logic              ramping;
    logic              tgt_up;
    logic [DUTY_W-1:0] steps;
    logic [DUR_W-1:0]  elap_inc;
    logic              step_due;
    logic [DUTY_W-1:0] duty_step;
    logic              div_done;
    logic [DUR_W-1:0]  quotient;

    assign cmd_in   = cmd_t'(command);
    assign ramping  = (dir_reg == DIR_UP) || (dir_reg == DIR_DOWN);
    assign tgt_up   = (target_duty > duty_reg);
    assign steps    = tgt_up ? (target_duty - duty_reg) : (duty_reg - target_duty);
    assign elap_inc = (elap_reg < ival_reg) ? (elap_reg + 16'd1) : elap_reg;
    assign step_due = !(elap_inc < ival_reg);

    always_comb
    begin
        if (dir_reg == DIR_UP)
            duty_step = (duty_reg != DUTY_MAX) ? (duty_reg + 8'd1) : duty_reg;
        else
            duty_step = (duty_reg != '0) ? (duty_reg - 8'd1) : duty_reg;
    end

    ldfr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (duration_ms),
        .divisor  (steps),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        en_next    = en_reg;
        duty_next  = duty_reg;
        tgt_next   = tgt_reg;
        dir_next   = dir_reg;
        ival_next  = ival_reg;
        elap_next  = elap_reg;
        wrote_next = wrote_reg;
        ovld_next  = ovld_reg;

        if (cfg_we)
            en_next = cfg_data;

        if (cmd.load)
        begin
            wrote_next = 1'b0;
            unique case (cmd_in)
                CMD_TICK:
                begin
                    if (ramping)
                    begin
                        elap_next = elap_inc;
                        if (step_due)
                        begin
                            elap_next  = '0;
                            duty_next  = duty_step;
                            wrote_next = en_reg;
                            if (duty_step == tgt_reg)
                                dir_next = DIR_NONE;
                        end
                    end
                end
                CMD_FADE:
                begin
                    tgt_next = target_duty;
                    if (target_duty == duty_reg)
                        dir_next = DIR_NONE;
                    else
                    begin
                        dir_next  = tgt_up ? DIR_UP : DIR_DOWN;
                        elap_next = '0;
                    end
                end
                CMD_SLEEP:
                begin
                    if (en_reg)
                    begin
                        duty_next  = '0;
                        tgt_next   = '0;
                        dir_next   = DIR_NONE;
                        wrote_next = 1'b1;
                    end
                end
                CMD_RESTORE:
                begin
                    wrote_next = en_reg;
                end
            endcase
        end

        if (div_done)
            ival_next = (quotient == '0) ? 16'd1 : quotient;

        if (cmd.emit)
            ovld_next = 1'b1;
        else if (out_ready)
            ovld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            duty_reg  <= DUTY_MAX;
            tgt_reg   <= DUTY_MAX;
            dir_reg   <= DIR_NONE;
            ival_reg  <= DEFAULT_INTERVAL;
            elap_reg  <= '0;
            wrote_reg <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            en_reg    <= en_next;
            duty_reg  <= duty_next;
            tgt_reg   <= tgt_next;
            dir_reg   <= dir_next;
            ival_reg  <= ival_next;
            elap_reg  <= elap_next;
            wrote_reg <= wrote_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            oduty_reg <= duty_reg;
            owr_reg   <= wrote_reg;
            oidle_reg <= !ramping || (duty_reg == tgt_reg);
        end
    end

    assign status.need_div = (cmd_in == CMD_FADE) && (target_duty != duty_reg);
    assign status.div_done = div_done;
    assign status.out_busy = ovld_reg && !out_ready;

    assign out_valid = ovld_reg;
    assign duty      = oduty_reg;
    assign pwm_write = owr_reg;
    assign idle      = oidle_reg;

    // elapsed count saturates at the interval
    a_elap_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        elap_reg <= ival_reg)
        else $error("elapsed count above step interval");

    // a zero interval would make every tick a step
    a_ival_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ival_reg != '0)
        else $error("step interval is zero");

    // an emitted result is never dropped onto a busy output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(ovld_reg && !out_ready))
        else $error("result emitted while output register busy");

endmodule

`default_nettype wire

@@ rtl/ldfr_ctrl.sv @@
// controller: sequences accept, divide and result emit
`default_nettype none

module ldfr_ctrl
    import ldfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load      = 1'b1;
                    cmd.div_start = status.need_div;
                    state_next    = status.need_div ? S_DIV : S_EMIT;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_div_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == S_DIV))
        else $error("divide started without entering divide state");

    a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> in_ready)
        else $error("not ready after emitting a result");

endmodule

`default_nettype wire

@@ rtl/linear_duty_fade_ramp_top.sv @@
// top level of the linear duty fade ramp backlight engine
`default_nettype none

// backlight fade engine: each input transaction is one command (tick of one
// millisecond, start fade, sleep, restore) and yields exactly one result
// transaction with the duty after the command, a pwm write flag and an idle
// flag. items are handled one at a time. a tick, sleep, restore, or a fade to
// the current duty goes from accept straight to the emit state. a fade to a
// different duty passes through the divide state first: the step interval
// duration / |target - duty| comes from a serial restoring divider that
// produces one quotient bit per cycle. the output register
// lets the next command be accepted while a result still waits on out_ready.
// output_enabled is written through the cfg channel, which is always ready;
// write it only while no command is in flight.

module linear_duty_fade_ramp_top
    import ldfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data,
    // command channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        command,
    input  wire logic [DUTY_W-1:0] target_duty,
    input  wire logic [DUR_W-1:0]  duration_ms,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DUTY_W-1:0]      duty,
    output logic                   pwm_write,
    output logic                   idle
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // the enable register takes a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: accept, optional divide, emit
    ldfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // ramp state, divider and result register
    ldfr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .command     (command),
        .target_duty (target_duty),
        .duration_ms (duration_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .duty        (duty),
        .pwm_write   (pwm_write),
        .idle        (idle)
    );

endmodule

`default_nettype wire
